FILE: rtl/ppp_pkg.sv
// Shared types, constants and helpers for the pinhole point projection unit.
// Depends on nothing; every other rtl file refers to it by scoped names.
`default_nettype none
package ppp_pkg;

  // Camera-frame coordinate width: Q16.16 rotated by Q2.14, then rounded back
  localparam int CamW    = 37;
  // f * |c| fits in this many bits
  localparam int NumW    = 67;
  // Quotient bits produced by the divider; bigger quotients saturate anyway
  localparam int QuoW    = 34;
  localparam int RotFrac = 14;
  // Lane latency: abs, multiply, combine, range check, QuoW steps, round, centre
  localparam int LaneLat = 4 + QuoW + 2;
  // Transform latency
  localparam int XfLat   = 2;
  // Total pipeline depth from input register to output register
  localparam int PipeLat = XfLat + LaneLat + 1;

  typedef enum logic [3:0] {
    REG_ROT0   = 4'd0,
    REG_ROT1   = 4'd1,
    REG_ROT2   = 4'd2,
    REG_T_XY   = 4'd3,
    REG_T_Z    = 4'd4,
    REG_FOCAL  = 4'd5,
    REG_CTR_U  = 4'd6,
    REG_CTR_V  = 4'd7
  } reg_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] image_u;
    logic signed [31:0] image_v;
    logic signed [31:0] cam_depth;
    logic               in_front;
    logic               zero_depth;
  } result_t;

  typedef struct packed {
    logic [47:0]        rot0;
    logic [47:0]        rot1;
    logic [47:0]        rot2;
    logic [63:0]        t_xy;
    logic signed [31:0] t_z;
    logic [30:0]        focal;
    logic signed [31:0] ctr_u;
    logic signed [31:0] ctr_v;
  } cfg_t;

  typedef struct packed {
    logic signed [CamW-1:0] xc;
    logic signed [CamW-1:0] yc;
    logic signed [CamW-1:0] zc;
  } cam_t;

  // Depth side band that rides next to the two divider lanes
  typedef struct packed {
    logic signed [31:0] depth;
    logic               in_front;
    logic               zero_depth;
  } depth_t;

  // Clamp a 37-bit signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [36:0] hi;
    logic signed [36:0] lo;
    hi = 37'sh0_7FFF_FFFF;
    lo = -37'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ppp_xform.sv
// Rigid transform stage: rotation (Q2.14) plus translation, two register stages.
// Uses ppp_pkg types and constants.
`default_nettype none
module ppp_xform (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire ppp_pkg::point_t point_i,
  input  wire ppp_pkg::cfg_t cfg_i,
  output ppp_pkg::cam_t      cam_o
);

  logic        [47:0] row   [3];
  logic signed [31:0] pt_x  [3];
  logic signed [15:0] rot_x [3][3];
  logic signed [47:0] prod_d [3][3];
  logic signed [47:0] prod_q [3][3];
  logic signed [50:0] trans [3];
  logic signed [50:0] acc   [3];

  // Split the rotation rows into signed entries; nine 16 x 32 products
  always_comb begin
    row[0]  = cfg_i.rot0;
    row[1]  = cfg_i.rot1;
    row[2]  = cfg_i.rot2;
    pt_x[0] = point_i.point_x;
    pt_x[1] = point_i.point_y;
    pt_x[2] = point_i.point_z;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        rot_x[r][k]  = row[r][16*k +: 16];
        prod_d[r][k] = rot_x[r][k] * pt_x[k];
      end
    end
  end

  // Stage 1: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // Stage 2: row sums, translation, round half up and drop the rotation fraction
  always_comb begin
    trans[0] = {{5{cfg_i.t_xy[31]}}, cfg_i.t_xy[31:0], {ppp_pkg::RotFrac{1'b0}}};
    trans[1] = {{5{cfg_i.t_xy[63]}}, cfg_i.t_xy[63:32], {ppp_pkg::RotFrac{1'b0}}};
    trans[2] = {{5{cfg_i.t_z[31]}}, cfg_i.t_z, {ppp_pkg::RotFrac{1'b0}}};
    for (int r = 0; r < 3; r++) begin
      acc[r] = 51'(prod_q[r][0]) + 51'(prod_q[r][1]) + 51'(prod_q[r][2])
             + trans[r] + 51'sd8192;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cam_o.xc <= acc[0][50:ppp_pkg::RotFrac];
      cam_o.yc <= acc[1][50:ppp_pkg::RotFrac];
      cam_o.zc <= acc[2][50:ppp_pkg::RotFrac];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ppp_lane.sv
// One projection lane: f*c/z rounded to nearest, signed, plus centre, saturated.
// Restoring divider, one quotient bit per stage. Uses ppp_pkg constants and sat32.
`default_nettype none
module ppp_lane (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic signed [ppp_pkg::CamW-1:0] c_i,
  input  wire logic signed [ppp_pkg::CamW-1:0] z_i,
  input  wire logic        [30:0]              focal_i,
  input  wire logic signed [31:0]              centre_i,
  output logic signed      [31:0]              res_o
);

  localparam int CW = ppp_pkg::CamW;
  localparam int QW = ppp_pkg::QuoW;
  localparam int NW = ppp_pkg::NumW;

  // Stage A: magnitudes and result sign
  logic [CW-1:0] ac_a_q, d_a_q;
  logic          neg_a_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q <= c_i[CW-1] ^ z_i[CW-1];
      ac_a_q  <= c_i[CW-1] ? CW'(-c_i) : CW'(c_i);
      d_a_q   <= z_i[CW-1] ? CW'(-z_i) : CW'(z_i);
    end
  end

  // Stage B: two partial products of f * |c|
  logic [49:0]   lo_b_q;
  logic [48:0]   hi_b_q;
  logic [CW-1:0] d_b_q;
  logic          neg_b_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_b_q  <= 50'(focal_i) * 50'(ac_a_q[18:0]);
      hi_b_q  <= 49'(focal_i) * 49'(ac_a_q[CW-1:19]);
      d_b_q   <= d_a_q;
      neg_b_q <= neg_a_q;
    end
  end

  // Stage C: dividend
  logic [NW-1:0] num_c_q;
  logic [CW-1:0] d_c_q;
  logic          neg_c_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_c_q <= NW'(lo_b_q) + NW'({hi_b_q, 19'b0});
      d_c_q   <= d_b_q;
      neg_c_q <= neg_b_q;
    end
  end

  // Divider state, index 0 is the range-check stage
  logic [CW-1:0] rem_q [QW+1];
  logic [QW-1:0] low_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [CW-1:0] dv_q  [QW+1];
  logic          neg_q [QW+1];
  logic          ovf_q [QW+1];

  // Stage D: quotient at or above 2^QW saturates; else top bits are the first remainder
  logic [CW-1:0] top_d;
  assign top_d = CW'(num_c_q[NW-1:QW]);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= top_d;
      low_q[0] <= num_c_q[QW-1:0];
      quo_q[0] <= '0;
      dv_q[0]  <= d_c_q;
      neg_q[0] <= neg_c_q;
      ovf_q[0] <= top_d >= d_c_q;
    end
  end

  // One restoring step per stage
  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [CW:0] trial;
    logic        ge;
    assign trial = {rem_q[i], low_q[i][QW-1]};
    assign ge    = trial >= {1'b0, dv_q[i]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge ? CW'(trial - {1'b0, dv_q[i]}) : trial[CW-1:0];
        low_q[i+1] <= {low_q[i][QW-2:0], 1'b0};
        quo_q[i+1] <= {quo_q[i][QW-2:0], ge};
        dv_q[i+1]  <= dv_q[i];
        neg_q[i+1] <= neg_q[i];
        ovf_q[i+1] <= ovf_q[i];
      end
    end
  end

  // Stage E: round half away from zero, apply sign
  logic          rnd_e;
  logic [QW:0]   mag_e;
  logic signed [QW+1:0] val_e_q;
  always_comb begin
    rnd_e = {rem_q[QW], 1'b0} >= {1'b0, dv_q[QW]};
    if (ovf_q[QW]) begin
      mag_e = {1'b1, {QW{1'b0}}};
    end else begin
      mag_e = (QW+1)'(quo_q[QW]) + (QW+1)'(rnd_e);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_e_q <= neg_q[QW] ? -$signed({1'b0, mag_e}) : $signed({1'b0, mag_e});
    end
  end

  // Stage F: add the principal point and clamp
  logic signed [36:0] sum_f;
  assign sum_f = 37'(val_e_q) + 37'(centre_i);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= ppp_pkg::sat32(sum_f);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pinhole_point_projection_unit.sv
// Channel | dir | handshake                 | payload
// in      | in  | in_valid_i / in_stall_o   | in_data_i  (ppp_pkg::point_t)
// out     | out | out_valid_o / out_stall_i | out_data_o (ppp_pkg::result_t)
// cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// One point per cycle unless the output stalls; data runs through the transform, the lanes and the output register.
// The 34-stage restoring divider in each lane sets the depth.
// A stalled output freezes every stage at once; bubbles are not squeezed out.
// Reset clears valid bits and loads the identity camera with f = 1.0.
// Configuration ready is always high; writes belong between transactions.
// Top level; uses ppp_pkg, ppp_xform and ppp_lane.
`default_nettype none
module pinhole_point_projection_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire ppp_pkg::point_t  in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output ppp_pkg::result_t      out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [3:0]       cfg_index_i,
  input  wire logic [63:0]      cfg_data_i
);

  localparam int PL = ppp_pkg::PipeLat;
  localparam int LL = ppp_pkg::LaneLat;

  ppp_pkg::cfg_t cfg_q;
  logic          en;
  logic          valid_q [PL];

  // Global advance: hold everything while the output is stalled
  assign en          = ~(out_valid_o & out_stall_i);
  assign in_stall_o  = ~en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = valid_q[PL-1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot0  <= 48'h0000_0000_4000;
      cfg_q.rot1  <= 48'h0000_4000_0000;
      cfg_q.rot2  <= 48'h4000_0000_0000;
      cfg_q.t_xy  <= '0;
      cfg_q.t_z   <= '0;
      cfg_q.focal <= 31'h0001_0000;
      cfg_q.ctr_u <= '0;
      cfg_q.ctr_v <= '0;
    end else if (cfg_valid_i) begin
      case (ppp_pkg::reg_e'(cfg_index_i))
        ppp_pkg::REG_ROT0:  cfg_q.rot0  <= cfg_data_i[47:0];
        ppp_pkg::REG_ROT1:  cfg_q.rot1  <= cfg_data_i[47:0];
        ppp_pkg::REG_ROT2:  cfg_q.rot2  <= cfg_data_i[47:0];
        ppp_pkg::REG_T_XY:  cfg_q.t_xy  <= cfg_data_i;
        ppp_pkg::REG_T_Z:   cfg_q.t_z   <= cfg_data_i[31:0];
        ppp_pkg::REG_FOCAL: cfg_q.focal <= cfg_data_i[30:0];
        ppp_pkg::REG_CTR_U: cfg_q.ctr_u <= cfg_data_i[31:0];
        ppp_pkg::REG_CTR_V: cfg_q.ctr_v <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Valid bits, one per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PL; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (en) begin
      valid_q[0] <= in_valid_i;
      for (int i = 1; i < PL; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  // World to camera frame
  ppp_pkg::cam_t cam;
  ppp_xform u_xform (
    .clk_i   (clk_i),
    .en_i    (en),
    .point_i (in_data_i),
    .cfg_i   (cfg_q),
    .cam_o   (cam)
  );

  // Projection lanes
  logic signed [31:0] u_res, v_res;
  ppp_lane u_lane_u (
    .clk_i    (clk_i),
    .en_i     (en),
    .c_i      (cam.xc),
    .z_i      (cam.zc),
    .focal_i  (cfg_q.focal),
    .centre_i (cfg_q.ctr_u),
    .res_o    (u_res)
  );

  ppp_lane u_lane_v (
    .clk_i    (clk_i),
    .en_i     (en),
    .c_i      (cam.yc),
    .z_i      (cam.zc),
    .focal_i  (cfg_q.focal),
    .centre_i (cfg_q.ctr_v),
    .res_o    (v_res)
  );

  // Depth side band, delayed to line up with the lanes
  ppp_pkg::depth_t sb_d;
  ppp_pkg::depth_t sb_q [LL];
  always_comb begin
    sb_d.depth      = ppp_pkg::sat32(cam.zc);
    sb_d.in_front   = $signed({cam.zc[ppp_pkg::CamW-1], cam.zc})
                      >= $signed({7'b0, cfg_q.focal});
    sb_d.zero_depth = cam.zc == '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sb_d;
      for (int i = 1; i < LL; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o.image_u    <= sb_q[LL-1].zero_depth ? '0 : u_res;
      out_data_o.image_v    <= sb_q[LL-1].zero_depth ? '0 : v_res;
      out_data_o.cam_depth  <= sb_q[LL-1].depth;
      out_data_o.in_front   <= sb_q[LL-1].in_front;
      out_data_o.zero_depth <= sb_q[LL-1].zero_depth;
    end
  end

  // Zero depth forces the image point to the origin
  a_zero_uv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_depth |->
      out_data_o.image_u == '0 && out_data_o.image_v == '0)
    else $error("zero depth with nonzero image point");

  // Zero flag agrees with the reported depth
  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_depth |-> out_data_o.cam_depth == '0)
    else $error("zero depth flag with nonzero depth");

  // A point behind the camera is never in front
  a_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.cam_depth[31] |-> !out_data_o.in_front)
    else $error("negative depth flagged in front");

  // Without a stall the last valid bit follows the one before it
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && out_stall_i) |=> out_valid_o == $past(valid_q[PL-2]))
    else $error("pipeline valid chain broken");

endmodule
`default_nettype wire
